// ----- sv/i2cm_pkg.sv -----
// Package for the I2C master byte engine: command codes, phase tables and the
// queued command record. No dependencies.
package i2cm_pkg;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_INIT  = 3'd1,
    OP_START = 3'd2,
    OP_STOP  = 3'd3,
    OP_WRITE = 3'd4,
    OP_READ  = 3'd5
  } op_e;

  localparam int unsigned QueueDepth = 2;
  localparam logic [7:0]  DelayReset = 8'd5;

  // Step tables, bit i belongs to step i. Line bit: 0 = SCL, 1 = SDA.
  localparam logic [4:0] StartLine = 5'b01010;
  localparam logic [4:0] StartVal  = 5'b00110;
  localparam logic [3:0] StopLine  = 4'b1010;
  localparam logic [3:0] StopVal   = 4'b1100;

  localparam logic [4:0] StartSteps = 5'd5;
  localparam logic [4:0] StopSteps  = 5'd4;

  // Last step of each command.
  localparam logic [4:0] LastInit  = 5'd0;
  localparam logic [4:0] LastStart = 5'd4;
  localparam logic [4:0] LastStop  = 5'd3;
  localparam logic [4:0] LastByte  = 5'd26;

  localparam logic [1:0] PhSetSda = 2'd0;
  localparam logic [1:0] PhSclHi  = 2'd1;
  localparam logic [1:0] PhSample = 2'd2;
  localparam logic [3:0] AckSlot  = 4'd8;

  // Classified request as it sits in the queue.
  typedef struct packed {
    op_e        op;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_in;
  } cmd_t;

  // Front-to-back link.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_link_t;

endpackage

// ----- sv/i2cm_if.sv -----
// Request and result channel interfaces of the I2C master byte engine.
// Standalone; used by the top level and its neighbors.
interface i2cm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] write_data;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, op, write_data, send_ack, sda_in, input ready);
  modport sink   (input valid, op, write_data, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       ack_bit;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_byte,
                  ack_bit, input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_byte,
                  ack_bit, output ready);
endinterface

// ----- sv/i2cm_front.sv -----
// Front end: takes requests, folds unused op codes into "none" and holds them
// in a short queue for the sequencer. Depends on i2cm_pkg.
module i2cm_front #(
  parameter int unsigned Depth = i2cm_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [2:0]          op_i,
  input  logic [7:0]          write_data_i,
  input  logic                send_ack_i,
  input  logic                sda_in_i,
  output logic                ready_o,
  output i2cm_pkg::cmd_link_t link_o,
  input  logic                pop_i
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2cm_pkg::cmd_t      slot_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  i2cm_pkg::cmd_t      cmd_in;
  logic                do_push, do_pop;

  // Classify: codes above read are plain ticks.
  always_comb begin
    cmd_in.write_data = write_data_i;
    cmd_in.send_ack   = send_ack_i;
    cmd_in.sda_in     = sda_in_i;
    if (op_i > i2cm_pkg::OP_READ) begin
      cmd_in.op = i2cm_pkg::OP_NONE;
    end else begin
      cmd_in.op = i2cm_pkg::op_e'(op_i);
    end
  end

  assign ready_o = (cnt_q != CntW'(Depth));
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign link_o.valid = (cnt_q != '0);
  assign link_o.cmd   = slot_q[rd_ptr_q];
endmodule

// ----- sv/i2cm_back.sv -----
// Back end: bus phase sequencer that runs one tick per queued request, plus
// the registered result stage. Depends on i2cm_pkg.
module i2cm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          delay_ticks_i,
  input  i2cm_pkg::cmd_link_t link_i,
  output logic                pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic                scl_out_o,
  output logic                sda_out_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [7:0]          read_byte_o,
  output logic                ack_bit_o
);
  i2cm_pkg::op_e run_q, run_d;
  logic [4:0] step_q, step_d;
  logic [3:0] slot_q, slot_d;
  logic [1:0] ph_q, ph_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] shift_q, shift_d;
  logic       scl_q, scl_d, sda_q, sda_d, ackf_q, ackf_d, choice_q, choice_d;
  logic [7:0] last_q, last_d;
  logic       out_vld_q;
  logic [7:0] dly;
  logic       busy, done, do_ph, wr, line, lval;
  logic [4:0] last_step;

  assign pop_o = link_i.valid && (!out_vld_q || res_ready_i);
  assign dly   = (delay_ticks_i == '0) ? 8'd1 : delay_ticks_i;

  always_comb begin
    run_d    = run_q;
    step_d   = step_q;
    slot_d   = slot_q;
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ackf_d   = ackf_q;
    choice_d = choice_q;
    last_d   = last_q;
    busy     = 1'b0;
    done     = 1'b0;
    do_ph    = 1'b0;
    wr       = 1'b0;
    line     = 1'b0;
    lval     = 1'b0;
    last_step = i2cm_pkg::LastByte;

    if (pop_o) begin
      if (run_q == i2cm_pkg::OP_NONE) begin
        if (link_i.cmd.op != i2cm_pkg::OP_NONE) begin
          run_d  = link_i.cmd.op;
          step_d = '0;
          slot_d = '0;
          ph_d   = i2cm_pkg::PhSetSda;
          if (link_i.cmd.op == i2cm_pkg::OP_WRITE) begin
            shift_d = link_i.cmd.write_data;
          end else if (link_i.cmd.op == i2cm_pkg::OP_READ) begin
            shift_d  = '0;
            choice_d = link_i.cmd.send_ack;
          end
          do_ph = 1'b1;
          busy  = 1'b1;
        end
      end else begin
        busy = 1'b1;
        if (cnt_q != '0) begin
          cnt_d = cnt_q - 8'd1;
        end else begin
          step_d = step_q + 5'd1;
          if (ph_q == i2cm_pkg::PhSample) begin
            ph_d   = i2cm_pkg::PhSetSda;
            slot_d = slot_q + 4'd1;
          end else begin
            ph_d = ph_q + 2'd1;
          end
          do_ph = 1'b1;
        end
      end

      if (do_ph) begin
        cnt_d = dly - 8'd1;
        wr    = (run_d == i2cm_pkg::OP_WRITE);
        unique case (run_d)
          i2cm_pkg::OP_INIT: begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end
          i2cm_pkg::OP_START: begin
            if (step_d < i2cm_pkg::StartSteps) begin
              line = i2cm_pkg::StartLine[step_d[2:0]];
              lval = i2cm_pkg::StartVal[step_d[2:0]];
              if (line) sda_d = lval;
              else      scl_d = lval;
            end
          end
          i2cm_pkg::OP_STOP: begin
            if (step_d < i2cm_pkg::StopSteps) begin
              line = i2cm_pkg::StopLine[step_d[1:0]];
              lval = i2cm_pkg::StopVal[step_d[1:0]];
              if (line) sda_d = lval;
              else      scl_d = lval;
            end
          end
          default: begin
            // Write or read: three phases per bit slot.
            unique case (ph_d)
              i2cm_pkg::PhSetSda: begin
                if (slot_d < i2cm_pkg::AckSlot) sda_d = wr ? shift_d[7] : 1'b1;
                else                            sda_d = wr ? 1'b1 : !choice_d;
              end
              i2cm_pkg::PhSclHi: scl_d = 1'b1;
              default: begin
                if (wr) begin
                  if (slot_d < i2cm_pkg::AckSlot) shift_d = {shift_d[6:0], 1'b0};
                  else                            ackf_d  = link_i.cmd.sda_in;
                end else if (slot_d < i2cm_pkg::AckSlot) begin
                  shift_d = {shift_d[6:0], link_i.cmd.sda_in};
                end
                scl_d = 1'b0;
              end
            endcase
          end
        endcase
      end

      unique case (run_d)
        i2cm_pkg::OP_INIT:  last_step = i2cm_pkg::LastInit;
        i2cm_pkg::OP_START: last_step = i2cm_pkg::LastStart;
        i2cm_pkg::OP_STOP:  last_step = i2cm_pkg::LastStop;
        default:            last_step = i2cm_pkg::LastByte;
      endcase

      if (busy && cnt_d == '0 && step_d >= last_step) begin
        done = 1'b1;
        if (run_d == i2cm_pkg::OP_READ) last_d = shift_d;
        run_d  = i2cm_pkg::OP_NONE;
        step_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= i2cm_pkg::OP_NONE;
      step_q    <= '0;
      slot_q    <= '0;
      ph_q      <= i2cm_pkg::PhSetSda;
      cnt_q     <= '0;
      shift_q   <= '0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
      ackf_q    <= 1'b1;
      choice_q  <= 1'b0;
      last_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      run_q    <= run_d;
      step_q   <= step_d;
      slot_q   <= slot_d;
      ph_q     <= ph_d;
      cnt_q    <= cnt_d;
      shift_q  <= shift_d;
      scl_q    <= scl_d;
      sda_q    <= sda_d;
      ackf_q   <= ackf_d;
      choice_q <= choice_d;
      last_q   <= last_d;
      if (pop_o) begin
        out_vld_q <= 1'b1;
      end else if (res_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload register, loaded on every processed tick.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      scl_out_o   <= scl_d;
      sda_out_o   <= sda_d;
      busy_res_o  <= busy;
      done_res_o  <= done;
      read_byte_o <= last_d;
      ack_bit_o   <= ackf_d;
    end
  end

  assign res_valid_o = out_vld_q;
endmodule

// ----- sv/i2c_master_byte_engine.sv -----
// Top level of the I2C master byte engine: APB delay register, request queue
// front end and phase sequencer back end. Depends on i2cm_pkg, i2cm_if,
// i2cm_front and i2cm_back.
//
//   channel   | dir | handshake        | payload
//   ----------+-----+------------------+---------------------------------------
//   req_i     | in  | valid / ready    | op, write_data, send_ack, sda_in
//   res_o     | out | valid / ready    | scl_out, sda_out, busy_res, done_res,
//             |     |                  | read_byte, ack_bit
//   APB       | in  | psel/penable     | delay_ticks at byte address 0
//
// One request is one bus-timer tick and yields exactly one result.
// Throughput is one request per cycle while res_o is not stalled; a request
// passes a queue slot, then the result register loaded by the sequencer.
// The two-entry queue lets req_i take requests while res_o stalls, until full.
// Reset puts the sequencer's lines released (SCL=1, SDA=1), ack 1, read byte 0.
module i2c_master_byte_engine #(
  parameter int unsigned QueueDepth = i2cm_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_req_if.sink    req_i,
  i2cm_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0]          delay_q;
  logic                cfg_wr;
  logic                pop;
  i2cm_pkg::cmd_link_t link;

  // Configuration: one register, word index paddr[2].
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {24'd0, delay_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= i2cm_pkg::DelayReset;
    end else if (cfg_wr) begin
      delay_q <= pwdata[7:0];
    end
  end

  i2cm_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (req_i.valid),
    .op_i         (req_i.op),
    .write_data_i (req_i.write_data),
    .send_ack_i   (req_i.send_ack),
    .sda_in_i     (req_i.sda_in),
    .ready_o      (req_i.ready),
    .link_o       (link),
    .pop_i        (pop)
  );

  i2cm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delay_ticks_i (delay_q),
    .link_i        (link),
    .pop_o         (pop),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .scl_out_o     (res_o.scl_out),
    .sda_out_o     (res_o.sda_out),
    .busy_res_o    (res_o.busy_res),
    .done_res_o    (res_o.done_res),
    .read_byte_o   (res_o.read_byte),
    .ack_bit_o     (res_o.ack_bit)
  );

  // An accepted request is queued on the next cycle.
  a_req_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> link.valid)
    else $error("accepted request missing from queue");

  // With the result stage empty, a queued request is sequenced at once.
  a_back_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link.valid && !res_o.valid |=> res_o.valid)
    else $error("sequencer did not take queued request");

  // Completion is only flagged on a busy tick.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> res_o.busy_res)
    else $error("done without busy");
endmodule

// ----- tb/i2cm_tb_pkg.sv -----
// Testbench constants shared by the checker and the stimulus top of the I2C
// master byte engine bench. Depends on nothing.
package i2cm_tb_pkg;

  // APB byte addresses: the delay register and an address with no register
  localparam logic [2:0] DelayAddr = 3'd0;
  localparam logic [2:0] SpareAddr = 3'd4;

  // op codes the block must treat as no command
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

endpackage

// ----- tb/i2cm_checker.sv -----
// Checker for the I2C master byte engine: follows the bus sequencer tick by
// tick and compares every result and every delay readback.
// Depends on i2cm_pkg, i2cm_tb_pkg and the request/result interfaces.
module i2cm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  i2cm_req_if         req,
  i2cm_res_if         res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned checked
);
  import i2cm_pkg::*;
  import i2cm_tb_pkg::*;

  localparam logic [1:0] StepSetSda = 2'd0;
  localparam logic [1:0] StepSclHigh = 2'd1;
  localparam logic [3:0] AckSlotIdx = 4'd8;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rd_byte;
    logic       ack;
  } bus_obs_t;

  bus_obs_t bus_exp_q[$];

  op_e        run_op;
  logic [5:0] step;
  logic [7:0] hold_cnt;
  logic [7:0] shreg;
  logic       scl_q, sda_q, ack_q, ack_sel;
  logic [7:0] rd_q;
  logic [7:0] delay_q;
  int unsigned err_cnt, seen_cnt;

  // line moves of the current step; sampling happens on the SCL-low step
  function automatic void apply_step(logic sda_in);
    logic [3:0] slot;
    logic [1:0] sub;
    logic       wr;
    case (run_op)
      OP_INIT: begin
        sda_q = 1'b1;
        scl_q = 1'b1;
      end
      OP_START: begin
        case (step)
          6'd0: scl_q = 1'b0;
          6'd1: sda_q = 1'b1;
          6'd2: scl_q = 1'b1;
          6'd3: sda_q = 1'b0;
          6'd4: scl_q = 1'b0;
          default: ;
        endcase
      end
      OP_STOP: begin
        case (step)
          6'd0: scl_q = 1'b0;
          6'd1: sda_q = 1'b0;
          6'd2: scl_q = 1'b1;
          6'd3: sda_q = 1'b1;
          default: ;
        endcase
      end
      default: begin
        slot = 4'(step / 3);
        sub  = 2'(step % 3);
        wr   = (run_op == OP_WRITE);
        if (sub == StepSetSda) begin
          if (slot < AckSlotIdx) sda_q = wr ? shreg[7] : 1'b1;
          else sda_q = wr ? 1'b1 : !ack_sel;
        end else if (sub == StepSclHigh) begin
          scl_q = 1'b1;
        end else begin
          if (wr) begin
            if (slot < AckSlotIdx) shreg = shreg << 1;
            else ack_q = sda_in;
          end else if (slot < AckSlotIdx) begin
            shreg = {shreg[6:0], sda_in};
          end
          scl_q = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic bus_obs_t bus_tick(logic [2:0] op, logic [7:0] data, logic sack,
                                        logic sda_in);
    logic [7:0] ticks;
    logic [5:0] last;
    logic       busy, done;
    ticks = (delay_q == 8'd0) ? 8'd1 : delay_q;
    busy  = 1'b0;
    done  = 1'b0;
    if (run_op == OP_NONE) begin
      if (op >= OP_INIT && op <= OP_READ) begin
        run_op = op_e'(op);
        step   = '0;
        if (op == OP_WRITE) begin
          shreg = data;
        end else if (op == OP_READ) begin
          shreg   = '0;
          ack_sel = sack;
        end
        apply_step(sda_in);
        hold_cnt = ticks - 8'd1;
        busy     = 1'b1;
      end
    end else begin
      if (hold_cnt != 0) begin
        hold_cnt--;
      end else begin
        step = step + 6'd1;
        apply_step(sda_in);
        hold_cnt = ticks - 8'd1;
      end
      busy = 1'b1;
    end
    case (run_op)
      OP_INIT:  last = 6'd0;
      OP_START: last = 6'd4;
      OP_STOP:  last = 6'd3;
      default:  last = 6'd26;
    endcase
    if (busy && hold_cnt == 0 && step >= last) begin
      done = 1'b1;
      if (run_op == OP_READ) rd_q = shreg;
      run_op = OP_NONE;
      step   = '0;
    end
    return '{scl: scl_q, sda: sda_q, busy: busy, done: done, rd_byte: rd_q, ack: ack_q};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    bus_obs_t want, got;
    if (!rst_ni) begin
      run_op   = OP_NONE;
      step     = '0;
      hold_cnt = '0;
      shreg    = '0;
      scl_q    = 1'b1;
      sda_q    = 1'b1;
      ack_q    = 1'b1;
      ack_sel  = 1'b0;
      rd_q     = '0;
      delay_q  = DelayReset;
      err_cnt  = 0;
      seen_cnt = 0;
      bus_exp_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite && paddr == DelayAddr) begin
          delay_q = pwdata[7:0];
        end else if (!pwrite && paddr == DelayAddr && prdata[7:0] !== delay_q) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("delay readback mismatch: expected %02h got %02h", delay_q, prdata[7:0]);
        end
      end
      if (req.valid && req.ready)
        bus_exp_q.push_back(bus_tick(req.op, req.write_data, req.send_ack, req.sda_in));
      if (res.valid && res.ready) begin
        got = '{scl: res.scl_out, sda: res.sda_out, busy: res.busy_res, done: res.done_res,
                rd_byte: res.read_byte, ack: res.ack_bit};
        seen_cnt++;
        if (bus_exp_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("result %0d arrived with nothing expected", seen_cnt);
        end else begin
          want = bus_exp_q.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $write("result %0d: expected scl=%b sda=%b busy=%b done=%b rd=%02h ack=%b,",
                     seen_cnt, want.scl, want.sda, want.busy, want.done, want.rd_byte,
                     want.ack);
              $display(" got scl=%b sda=%b busy=%b done=%b rd=%02h ack=%b",
                       got.scl, got.sda, got.busy, got.done, got.rd_byte, got.ack);
            end
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending    <= bus_exp_q.size();
    checked    <= seen_cnt;
  end

endmodule

// ----- tb/testbench.sv -----
// Stimulus top for the I2C master byte engine: drives bus ticks and APB delay
// writes, paces the result side, gives the verdict.
// Depends on i2cm_pkg, i2cm_tb_pkg, i2cm_if, i2cm_checker and the block.
module testbench;
  import i2cm_pkg::*;
  import i2cm_tb_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  // how the SDA input is driven across the ticks of one command
  typedef enum logic [1:0] {SDA_LOW, SDA_HIGH, SDA_RAND} sda_pat_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  i2cm_req_if req_if();
  i2cm_res_if res_if();

  int unsigned mismatches, pending, checked;
  int unsigned cycles = 0;
  int unsigned busy_left = 0;   // ticks the bus sequence still needs
  int unsigned ticks_sent = 0;
  int unsigned cmds_sent = 0;
  int unsigned eff_delay = DelayReset;
  bit          tx_quiet = 1'b0; // stretch with no sender gaps
  bit          rx_quiet = 1'b0; // stretch with no result stalls
  int unsigned stall_left;

  i2c_master_byte_engine DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  i2cm_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_if),
    .res        (res_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs on a handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: each result gets its own random stall before ready returns,
  // with occasional stretches of back-to-back acceptance.
  always @(posedge clk_i) begin : rx_pace
    int unsigned draw;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (res_if.valid && res_if.ready) begin
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      draw = rx_quiet ? 0 : $urandom_range(0, 16);
      res_if.ready <= (draw == 0);
      stall_left   <= draw;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= (stall_left == 1);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // Bus phases per command; times the delay gives the ticks it keeps busy.
  function automatic int unsigned cmd_phases(logic [2:0] op);
    case (op)
      OP_INIT:  return 1;
      OP_START: return 5;
      OP_STOP:  return 4;
      default:  return 27;
    endcase
  endfunction

  function automatic logic sda_bit(sda_pat_e pat);
    case (pat)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom);
    endcase
  endfunction

  // One bus tick as one request. Returns at the edge where it was taken;
  // valid stays high so the next request can follow without a bubble.
  task automatic drive_tick(logic [2:0] op, logic [7:0] data, logic sack, logic sda);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.write_data <= data;
    req_if.send_ack   <= sack;
    req_if.sda_in     <= sda;
    do @(posedge clk_i); while (!req_if.ready);
    ticks_sent++;
    // track the sequence length only to know when a new command will land
    if (busy_left != 0) begin
      busy_left--;
    end else if (op >= OP_INIT && op <= OP_READ) begin
      busy_left = cmd_phases(op) * eff_delay - 1;
      cmds_sent++;
    end
  endtask

  // A command followed by plain ticks until it completes; noise_op goes on
  // the first following tick, where the block must ignore it.
  task automatic run_cmd(logic [2:0] op, logic [7:0] data, logic sack, sda_pat_e pat,
                         logic [2:0] noise_op);
    bit first;
    first = 1'b1;
    drive_tick(op, data, sack, sda_bit(pat));
    while (busy_left != 0) begin
      drive_tick(first ? noise_op : OP_NONE, 8'($urandom), 1'($urandom), sda_bit(pat));
      first = 1'b0;
    end
  endtask

  // Random traffic: mostly real commands with random content, run to their
  // end, with ignored commands sprinkled over busy ticks and spare op codes
  // or empty ticks between commands. The last command is always finished.
  task automatic random_ticks(int unsigned budget);
    int unsigned stop_at, r;
    logic [2:0]  op;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at || busy_left != 0) begin
      if (busy_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          case ($urandom_range(0, 9))
            0:          op = OP_INIT;
            1:          op = OP_START;
            2:          op = OP_STOP;
            3, 4, 5, 6: op = OP_WRITE;
            default:    op = OP_READ;
          endcase
        end else if (r < 85) begin
          op = OP_NONE;
        end else begin
          op = $urandom_range(0, 1) ? OpSpare6 : OpSpare7;
        end
      end else begin
        op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(OP_INIT, OpSpare7)) : OP_NONE;
      end
      drive_tick(op, 8'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register writes only once every result is back; the sequencer itself may
  // still be mid-command, which is a legal case. Readback is checked.
  task automatic set_delay(logic [2:0] addr, logic [31:0] value);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    apb_access(1'b1, addr, value);
    apb_access(1'b0, DelayAddr, '0);
    if (addr == DelayAddr) eff_delay = (value[7:0] == 0) ? 1 : value[7:0];
  endtask

  initial begin : stimulus
    int unsigned w;
    req_if.valid      = 1'b0;
    req_if.op         = OP_NONE;
    req_if.write_data = '0;
    req_if.send_ack   = 1'b0;
    req_if.sda_in     = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, at the reset delay: readback of the reset value, idle ticks
    // with no-op and spare codes, init, start, a write and a stop, each with
    // a command thrown at the busy block.
    apb_access(1'b0, DelayAddr, '0);
    drive_tick(OP_NONE, 8'hFF, 1'b1, 1'b0);
    drive_tick(OpSpare6, 8'h00, 1'b0, 1'b1);
    drive_tick(OpSpare7, 8'hFF, 1'b1, 1'b0);
    run_cmd(OP_INIT, 8'h00, 1'b0, SDA_HIGH, OP_WRITE);
    run_cmd(OP_START, 8'h00, 1'b0, SDA_RAND, OP_STOP);
    run_cmd(OP_WRITE, 8'hFF, 1'b0, SDA_LOW, OP_READ);
    run_cmd(OP_STOP, 8'h5A, 1'b1, SDA_RAND, OP_START);

    // Delay change while a byte is still on the bus: the new value takes over
    // from the next phase. The remaining phases fit in the fixed tick count.
    set_delay(DelayAddr, 32'd2);
    drive_tick(OP_WRITE, 8'hA5, 1'b0, 1'($urandom));
    repeat (20) drive_tick(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
    set_delay(DelayAddr, 32'd3);
    repeat (27 * 3) drive_tick(OP_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
    busy_left = 0;

    // zero delay behaves as one tick per phase; data and SDA extremes,
    // ACK and NACK on reads
    set_delay(DelayAddr, 32'd0);
    run_cmd(OP_WRITE, 8'h00, 1'b1, SDA_HIGH, OP_NONE);
    run_cmd(OP_READ, 8'h00, 1'b1, SDA_HIGH, OP_INIT);
    run_cmd(OP_READ, 8'hFF, 1'b0, SDA_LOW, OpSpare7);
    random_ticks(40);

    // longest phase
    set_delay(DelayAddr, 32'd255);
    run_cmd(OP_INIT, 8'h00, 1'b0, SDA_RAND, OP_READ);

    // address without a register is a no-op; upper data bits are dropped
    set_delay(SpareAddr, 32'd9);
    set_delay(DelayAddr, 32'hFFFF_FF01);
    random_ticks(60);
    set_delay(DelayAddr, 32'd2);
    random_ticks(40);
    set_delay(DelayAddr, 32'd3);
    random_ticks(30);

    // drain: everything sent must come back, then the bench idles before the verdict
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    for (w = 0; w < 20000 && pending != 0; w++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d bus ticks carrying %0d commands, %0d results checked,",
             ticks_sent, cmds_sent, checked);
    $display("over phase lengths 5, 2, 3, 0, 255, 1, 2 and 3 ticks.");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/i2cm_pkg.sv
sv/i2cm_if.sv
sv/i2cm_front.sv
sv/i2cm_back.sv
sv/i2c_master_byte_engine.sv
tb/i2cm_tb_pkg.sv
tb/i2cm_checker.sv
tb/testbench.sv
